// ===== sv/ocr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the object code relocator.
// No dependencies; every file but ocr_ram imports this package.
package ocr_pkg;

  localparam int unsigned SYMBOL_SLOTS_DEF = 256;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BSS_BASE  = 2'd2;

  // Relocation codes of a first word
  localparam logic [15:0] RELOC_ABS     = 16'd0;
  localparam logic [15:0] RELOC_ABS_ALT = 16'd7;
  localparam logic [15:0] RELOC_LONG    = 16'd5;

  // Long types carried by the second word
  localparam logic [15:0] LONG_NONE    = 16'd0;
  localparam logic [15:0] LONG_DATA    = 16'd1;
  localparam logic [15:0] LONG_TEXT    = 16'd2;
  localparam logic [15:0] LONG_BSS     = 16'd3;
  localparam logic [2:0]  LONG_EXT_TAG = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CODE = 2'd1;
  localparam logic [1:0] STATUS_BAD_LONG = 2'd2;

  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_DATA,
    ADD_TEXT,
    ADD_BSS,
    ADD_EXT
  } add_sel_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        pair;
    logic [1:0]  status;
    logic [31:0] whole;
    add_sel_t    sel;
    logic [31:0] ext_val;
  } ocr_op_t;

endpackage

// ===== sv/object_code_relocator.sv =====
`timescale 1ns / 1ps
// Object code relocator, top level. Depends on ocr_pkg, ocr_front, ocr_queue,
// ocr_back (and ocr_ram through ocr_front).
//
// Input channel (in_valid / in_stall): a request either loads one symbol table
// slot (in_cmd = 0) or relocates one code word with its relocation word
// (in_cmd = 1). Loads and the high word of a long give no result; every other
// request gives one result, and the low word of a long gives two (high word
// first, out_last low on the first).
// Result channel (out_valid / out_stall): out_word, out_status, out_last.
// Config port: cfg_we writes cfg_wdata to text, data or bss base by cfg_index;
// write only while no request is in flight.
// A request passes the front stage register, the queue and the back end result
// register. Requests are taken one per cycle while in_stall is low; the output
// moves one word per cycle while out_stall is low, set by that single register.
// A stalled output holds its word; the two-entry queue and the front stage then
// fill, and in_stall rises once both are full.
// Reset clears the bases, the pending long and all queues. The symbol table is
// not cleared: a slot must be loaded before a long refers to it.
module object_code_relocator import ocr_pkg::*; #(
  parameter int unsigned SYMBOL_SLOTS = SYMBOL_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [15:0]            in_code_word,
  input  logic [15:0]            in_reloc_word,
  input  logic [7:0]             in_symbol_index,
  input  logic [31:0]            in_symbol_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_word,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  logic    q_push, q_full, q_pop, q_valid;
  ocr_op_t q_in, q_out;

  ocr_front #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_code_word    (in_code_word),
    .in_reloc_word   (in_reloc_word),
    .in_symbol_index (in_symbol_index),
    .in_symbol_value (in_symbol_value),
    .q_push          (q_push),
    .q_data          (q_in),
    .q_full          (q_full)
  );

  ocr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  ocr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

// ===== sv/ocr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ocr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ocr_queue.sv =====
`timescale 1ns / 1ps
// Short register queue of classified requests between front and back.
// Depends on ocr_pkg for the request type and depth.
module ocr_queue import ocr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  ocr_op_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output ocr_op_t pop_data
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  ocr_op_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/ocr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, keeps the pending-long state, owns the symbol
// table and hands classified requests to the queue. Depends on ocr_pkg, ocr_ram.
module ocr_front import ocr_pkg::*; #(
  parameter int unsigned SYMBOL_SLOTS = SYMBOL_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_code_word,
  input  logic [15:0] in_reloc_word,
  input  logic [7:0]  in_symbol_index,
  input  logic [31:0] in_symbol_value,
  output logic        q_push,
  output ocr_op_t     q_data,
  input  logic        q_full
);

  localparam int unsigned AW = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;

  logic          accept;
  logic          pending_r, pending_nxt;
  logic [15:0]   held_r, held_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  ocr_op_t       s1_op_r, op;
  logic          emit;
  logic          load_ok, slot_ok;
  logic [12:0]   slot;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  assign slot      = in_reloc_word[15:3];
  assign load_ok   = (32'(in_symbol_index) < 32'(SYMBOL_SLOTS));
  assign slot_ok   = (32'(slot) < 32'(SYMBOL_SLOTS));
  assign ram_waddr = AW'(in_symbol_index);
  assign ram_raddr = AW'(slot);

  always_comb begin
    pending_nxt = pending_r;
    held_nxt    = held_r;
    emit        = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    op.pair     = 1'b0;
    op.status   = STATUS_OK;
    op.whole    = {16'd0, in_code_word};
    op.sel      = ADD_NONE;
    op.ext_val  = '0;
    if (accept) begin
      if (!in_cmd) begin
        ram_we = load_ok;
      end else if (!pending_r) begin
        if (in_reloc_word == RELOC_ABS || in_reloc_word == RELOC_ABS_ALT) begin
          emit = 1'b1;
        end else if (in_reloc_word == RELOC_LONG) begin
          pending_nxt = 1'b1;
          held_nxt    = in_code_word;
        end else begin
          emit      = 1'b1;
          op.status = STATUS_BAD_CODE;
        end
      end else begin
        // Second half of a long: its relocation word picks the addend.
        pending_nxt = 1'b0;
        emit        = 1'b1;
        op.pair     = 1'b1;
        op.whole    = {held_r, in_code_word};
        if (in_reloc_word[2:0] == LONG_EXT_TAG) begin
          if (slot_ok) begin
            op.sel = ADD_EXT;
            ram_re = 1'b1;
          end else begin
            op.status = STATUS_BAD_LONG;
          end
        end else begin
          unique case (in_reloc_word)
            LONG_NONE: op.sel = ADD_NONE;
            LONG_DATA: op.sel = ADD_DATA;
            LONG_TEXT: op.sel = ADD_TEXT;
            LONG_BSS:  op.sel = ADD_BSS;
            default:   op.status = STATUS_BAD_LONG;
          endcase
        end
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = emit;
    end else if (s1_valid_r && !q_full) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pending_r  <= pending_nxt;
      held_r     <= held_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_op_r <= op;
    end
  end

  // The table read issued at accept lands in the RAM output register and
  // stays there while the stage waits, since no new request is taken.
  assign q_push = s1_valid_r && !q_full;
  always_comb begin
    q_data         = s1_op_r;
    q_data.ext_val = ram_rdata;
  end

  ocr_ram #(
    .WIDTH (32),
    .DEPTH (SYMBOL_SLOTS),
    .AW    (AW)
  ) u_symtab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_symbol_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== sv/ocr_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the section bases, adds the addend to a long and drives the
// result register, splitting a long into its two words. Depends on ocr_pkg.
module ocr_back import ocr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   q_valid,
  input  ocr_op_t                q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_word,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  logic [31:0] text_base_r, data_base_r, bss_base_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_word_r, out_word_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;
  logic        lo_pend_r, lo_pend_nxt;
  logic [15:0] lo_word_r, lo_word_nxt;
  logic        out_load;
  logic [31:0] addend, sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r <= '0;
      data_base_r <= '0;
      bss_base_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_BASE: text_base_r <= cfg_wdata;
        REG_DATA_BASE: data_base_r <= cfg_wdata;
        REG_BSS_BASE:  bss_base_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (q_data.sel)
      ADD_DATA: addend = data_base_r;
      ADD_TEXT: addend = text_base_r;
      ADD_BSS:  addend = bss_base_r;
      ADD_EXT:  addend = q_data.ext_val;
      default:  addend = '0;
    endcase
  end

  assign sum      = q_data.whole + addend;
  assign out_load = !out_valid_r || !out_stall;
  assign q_pop    = out_load && !lo_pend_r && q_valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    lo_pend_nxt    = lo_pend_r;
    lo_word_nxt    = lo_word_r;
    if (out_load) begin
      if (lo_pend_r) begin
        // Low word of a long; status is the one shown with the high word.
        out_valid_nxt = 1'b1;
        out_word_nxt  = lo_word_r;
        out_last_nxt  = 1'b1;
        lo_pend_nxt   = 1'b0;
      end else if (q_pop) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = q_data.status;
        if (q_data.pair) begin
          out_word_nxt = sum[31:16];
          out_last_nxt = 1'b0;
          lo_word_nxt  = sum[15:0];
          lo_pend_nxt  = 1'b1;
        end else begin
          out_word_nxt = q_data.whole[15:0];
          out_last_nxt = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lo_pend_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lo_pend_r   <= lo_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    lo_word_r    <= lo_word_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  // A held low word always sits behind a high word on the output.
  a_lo_behind_hi: assert property (@(posedge clk) disable iff (!rst_n)
    lo_pend_r |-> (out_valid_r && !out_last_r))
    else $error("low word pending without a high word on the output");

  // Once the high word is taken, the low word follows in the next cycle.
  a_lo_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r && !out_stall) |=> (out_valid_r && out_last_r))
    else $error("low word did not follow its high word");

  // An empty output takes queued work at once.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_valid_r) |=> out_valid_r)
    else $error("queued request left waiting behind an empty output");

endmodule

// ===== bench/tb_object_code_relocator.sv =====
`timescale 1ns / 1ps
// Self-checking bench for object_code_relocator: directed rows, then phases of
// random requests checked against a bit-accurate predictor. Depends on ocr_pkg.
module tb_object_code_relocator;
  import ocr_pkg::*;

  localparam logic                   CMD_LOAD  = 1'b0;
  localparam logic                   CMD_RELOC = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [15:0] LONG_KINDS [4] = '{LONG_NONE, LONG_DATA, LONG_TEXT, LONG_BSS};

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic        cmd;
    logic [15:0] code_word;
    logic [15:0] reloc_word;
    logic [7:0]  symbol_index;
    logic [31:0] symbol_value;
  } reloc_request_t;

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  status;
    logic        last;
  } reloc_result_t;

  // A fixed_count of -1 leaves the results to the predictor.
  typedef struct packed {
    reloc_request_t      req;
    int                  fixed_count;
    reloc_result_t [1:0] fixed;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_TEXT_BASE;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_cmd = CMD_LOAD;
  logic [15:0]            in_code_word = '0;
  logic [15:0]            in_reloc_word = '0;
  logic [7:0]             in_symbol_index = '0;
  logic [31:0]            in_symbol_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [15:0]            out_word;
  logic [1:0]             out_status;
  logic                   out_last;

  object_code_relocator #(.SYMBOL_SLOTS(SYMBOL_SLOTS_DEF)) uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_cmd, .in_code_word, .in_reloc_word,
    .in_symbol_index, .in_symbol_value,
    .out_valid, .out_stall, .out_word, .out_status, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0]   text_origin = '0;
  logic [31:0]   data_origin = '0;
  logic [31:0]   bss_origin = '0;
  logic          long_open = 1'b0;
  logic [15:0]   high_half = '0;
  logic [31:0]   symbol_values [SYMBOL_SLOTS_DEF];
  bit            slot_loaded [SYMBOL_SLOTS_DEF];
  int            loaded_slots [$];
  reloc_result_t words_due [$];
  directed_row_t directed_rows [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  words_checked = 0;
  int  long_pairs = 0;
  int  symbol_lookups = 0;
  int  base_settings = 0;
  int  gap_pct = 20;
  int  stall_pct = 20;
  bit  hold_output = 1'b0;
  int  quiet_cycles = 0;

  function automatic int relocate_request(input reloc_request_t r,
                                          output reloc_result_t [1:0] res);
    logic [31:0] whole;
    logic [31:0] addend;
    logic [1:0]  status;
    res = '0;
    if (r.cmd == CMD_LOAD) begin
      if (r.symbol_index < SYMBOL_SLOTS_DEF) begin
        symbol_values[r.symbol_index] = r.symbol_value;
        if (!slot_loaded[r.symbol_index]) loaded_slots.push_back(r.symbol_index);
        slot_loaded[r.symbol_index] = 1'b1;
      end
      return 0;
    end
    if (!long_open) begin
      if (r.reloc_word == RELOC_ABS || r.reloc_word == RELOC_ABS_ALT) begin
        res[0] = {r.code_word, STATUS_OK, 1'b1};
        return 1;
      end
      if (r.reloc_word == RELOC_LONG) begin
        high_half = r.code_word;
        long_open = 1'b1;
        return 0;
      end
      res[0] = {r.code_word, STATUS_BAD_CODE, 1'b1};
      return 1;
    end
    // Second half of a long: the relocation word picks the addend.
    long_open = 1'b0;
    long_pairs++;
    whole = {high_half, r.code_word};
    addend = '0;
    status = STATUS_OK;
    if (r.reloc_word[2:0] == LONG_EXT_TAG) begin
      if (r.reloc_word[15:3] < SYMBOL_SLOTS_DEF) begin
        addend = symbol_values[r.reloc_word[15:3]];
        symbol_lookups++;
      end else begin
        status = STATUS_BAD_LONG;
      end
    end else begin
      case (r.reloc_word)
        LONG_NONE: addend = '0;
        LONG_DATA: addend = data_origin;
        LONG_TEXT: addend = text_origin;
        LONG_BSS:  addend = bss_origin;
        default:   status = STATUS_BAD_LONG;
      endcase
    end
    if (status == STATUS_OK) whole = whole + addend;
    res[0] = {whole[31:16], status, 1'b0};
    res[1] = {whole[15:0], status, 1'b1};
    return 2;
  endfunction

  // Mostly well-formed streams: longs are opened and closed with a legal
  // type, and symbol lookups only touch slots that were loaded.
  function automatic reloc_request_t random_request();
    reloc_request_t r;
    int unsigned    pick;
    logic [12:0]    slot;
    r.cmd = CMD_RELOC;
    r.code_word = 16'($urandom());
    r.reloc_word = 16'($urandom());
    r.symbol_index = 8'($urandom());
    r.symbol_value = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.cmd = CMD_LOAD;
      if (pick < 2) r.symbol_value = '1;
    end else if (!long_open) begin
      if (pick < 55) r.reloc_word = RELOC_LONG;
      else if (pick < 70) r.reloc_word = RELOC_ABS;
      else if (pick < 85) r.reloc_word = RELOC_ABS_ALT;
    end else begin
      if (pick < 60) begin
        r.reloc_word = LONG_KINDS[$urandom_range(0, 3)];
      end else if (pick < 85) begin
        slot = 13'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        r.reloc_word = {slot, LONG_EXT_TAG};
      end else if (pick < 90) begin
        slot = 13'($urandom_range(SYMBOL_SLOTS_DEF, 8191));
        r.reloc_word = {slot, LONG_EXT_TAG};
      end else if (r.reloc_word[2:0] == LONG_EXT_TAG) begin
        // A random type must not turn into a lookup of an unloaded slot.
        r.reloc_word[0] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic add_row(input logic cmd, input logic [15:0] code, reloc,
                         input logic [7:0] idx, input logic [31:0] value,
                         input int n, input logic [15:0] w0, w1,
                         input logic [1:0] st);
    directed_row_t row;
    row.req = {cmd, code, reloc, idx, value};
    row.fixed_count = n;
    row.fixed = '0;
    if (n == 1) row.fixed[0] = {w0, st, 1'b1};
    if (n == 2) begin
      row.fixed[0] = {w0, st, 1'b0};
      row.fixed[1] = {w1, st, 1'b1};
    end
    directed_rows.push_back(row);
  endtask

  // Valid stays high after acceptance; only a pause or the next request
  // assigns it again, so it never gets two updates in one step.
  task automatic send_request(input directed_row_t row);
    reloc_result_t [1:0] predicted;
    int                  count;
    in_valid <= 1'b1;
    in_cmd <= row.req.cmd;
    in_code_word <= row.req.code_word;
    in_reloc_word <= row.req.reloc_word;
    in_symbol_index <= row.req.symbol_index;
    in_symbol_value <= row.req.symbol_value;
    do @(posedge clk); while (in_stall);
    count = relocate_request(row.req, predicted);
    if (row.fixed_count >= 0) begin
      count = row.fixed_count;
      predicted = row.fixed;
    end
    for (int i = 0; i < count; i++) words_due.push_back(predicted[i]);
    requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_bases(input logic [31:0] text_v, data_v, bss_v,
                               input bit poke_spare);
    cfg_we <= 1'b1;
    cfg_index <= REG_TEXT_BASE;
    cfg_wdata <= text_v;
    @(posedge clk);
    text_origin = text_v;
    cfg_index <= REG_DATA_BASE;
    cfg_wdata <= data_v;
    @(posedge clk);
    data_origin = data_v;
    cfg_index <= REG_BSS_BASE;
    cfg_wdata <= bss_v;
    @(posedge clk);
    bss_origin = bss_v;
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= $urandom();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    base_settings++;
  endtask

  always @(posedge clk) begin : check_words
    reloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (words_due.size() == 0) begin
        $display("%0t: expected no word, actual %h status %0d last %0b", $time,
                 out_word, out_status, out_last);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        if (out_word !== want.word) begin
          $display("%0t: out_word expected %h actual %h", $time, want.word, out_word);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: out_status expected %0d actual %0d", $time, want.status,
                   out_status);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("object_code_relocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int burst;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_output = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    logic [31:0]   t_v, d_v, b_v;
    // Bases are zero after reset, so most long results are read off directly.
    add_row(CMD_RELOC, 16'h0000, RELOC_ABS, 0, 0, 1, 16'h0000, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hFFFF, RELOC_ABS_ALT, 0, 0, 1, 16'hFFFF, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h1234, 16'h0001, 0, 0, 1, 16'h1234, 0, STATUS_BAD_CODE);
    add_row(CMD_RELOC, 16'hABCD, 16'hFFFF, 0, 0, 1, 16'hABCD, 0, STATUS_BAD_CODE);
    add_row(CMD_LOAD, 0, 0, 8'h00, 32'hFFFF_FFFF, -1, 0, 0, STATUS_OK);
    add_row(CMD_LOAD, 0, 0, 8'hFF, 32'h0000_0001, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hFFFF, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hFFFF, LONG_NONE, 0, 0, 2, 16'hFFFF, 16'hFFFF, STATUS_OK);
    add_row(CMD_RELOC, 16'h0001, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h0000, {13'd0, LONG_EXT_TAG}, 0, 0,
            2, 16'h0000, 16'hFFFF, STATUS_OK);
    add_row(CMD_RELOC, 16'h8000, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h0000, {13'd255, LONG_EXT_TAG}, 0, 0,
            2, 16'h8000, 16'h0001, STATUS_OK);
    // A second long code in the low half is not a valid long type.
    add_row(CMD_RELOC, 16'h1234, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h5678, RELOC_LONG, 0, 0, 2, 16'h1234, 16'h5678, STATUS_BAD_LONG);
    add_row(CMD_RELOC, 16'hABCD, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hEF01, {13'd256, LONG_EXT_TAG}, 0, 0,
            2, 16'hABCD, 16'hEF01, STATUS_BAD_LONG);
    // A table load between the halves must not disturb the held high word.
    add_row(CMD_RELOC, 16'h0000, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_LOAD, 0, 0, 8'h03, 32'h0000_0010, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h0000, {13'd3, LONG_EXT_TAG}, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hFFFF, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hFFFF, {13'h1FFF, LONG_EXT_TAG}, 0, 0,
            2, 16'hFFFF, 16'hFFFF, STATUS_BAD_LONG);
    add_row(CMD_RELOC, 16'h0123, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h4567, LONG_DATA, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h89AB, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'hCDEF, LONG_TEXT, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h0000, RELOC_LONG, 0, 0, -1, 0, 0, STATUS_OK);
    add_row(CMD_RELOC, 16'h0000, LONG_BSS, 0, 0, -1, 0, 0, STATUS_OK);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if ($urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 12));
      send_request(directed_rows[i]);
    end
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      t_v = $urandom();
      d_v = $urandom();
      b_v = $urandom();
      case (phase)
        0: begin t_v = '1; d_v = '1; b_v = '1; end
        1: begin t_v = '0; d_v = '0; b_v = '0; end
        3: begin t_v = 32'h8000_0000; d_v = 32'h7FFF_FFFF; b_v = 32'h0000_0001; end
        default: ;
      endcase
      program_bases(t_v, d_v, b_v, phase == 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // The final phase runs with no idling on either side.
        if (phase == PHASES - 1) begin
          gap_pct = 0;
          stall_pct = 0;
        end else if (k % 46 == 0) begin
          gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
          stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
        if (phase == 2 && k == 20) hold_output = 1'b1;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
          pause_sender($urandom_range(1, 12));
        row.req = random_request();
        row.fixed_count = -1;
        row.fixed = '0;
        send_request(row);
      end
      drain_results();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests under %0d base settings: %0d long pairs,",
             requests_sent, base_settings, long_pairs);
    $display("%0d symbol lookups and %0d result words compared.",
             symbol_lookups, words_checked);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("object_code_relocator test passed");
    end else begin
      $display("object_code_relocator test failed");
    end
    $finish;
  end

endmodule
